// ===== hw/rtl/lpcp_pkg.sv =====
// ----------------------------------------------------------------------------
// lpcp_pkg: shared types and constants for the lidar point projection core
// Field widths, register indexes, reset values and the cell payload struct.
// ----------------------------------------------------------------------------
package lpcp_pkg;

	localparam int CoordW = 20;
	localparam int CoefW  = 16;
	localparam int PixW   = 16;
	localparam int DepthW = 10;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 64;

	// Projection quotient magnitude: |c*f| < 2^35, z >= 1 -> quotient < 2^36
	localparam int NumW  = 36;
	localparam int QuoW  = NumW;
	// one restoring step per numerator bit (numerator is NumW+1 bits wide)
	localparam int DivSteps = NumW + 1;

	localparam logic [CfgIdxW-1:0] REG_ROT0  = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_ROT1  = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_ROT2  = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_TRANS = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_FOCAL = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_PP    = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_MIND  = 3'd6;

	localparam logic [47:0] ROT0_RST  = 48'd16384;
	localparam logic [47:0] ROT1_RST  = 48'd1073741824;
	localparam logic [47:0] ROT2_RST  = 48'd70368744177664;
	localparam logic [59:0] TRANS_RST = 60'd0;
	localparam logic [31:0] FOCAL_RST = 32'd1048592000;
	localparam logic [31:0] PP_RST    = 32'd377497600;
	localparam logic [DepthW-1:0] MIND_RST = 10'd102;

	localparam logic signed [CoordW-1:0] S20_MAX = 20'sd524287;
	localparam logic signed [CoordW-1:0] S20_MIN = -20'sd524288;

	// One channel (u or v) of a division in flight
	typedef struct packed {
		logic            neg;
		logic [NumW:0]   rem;   // partial remainder
		logic [NumW:0]   num;   // numerator bits still to shift in (2*mag + z)
		logic [QuoW-1:0] quo;
		logic [PixW-1:0] pp;
	} lpcp_div_t;

	typedef struct packed {
		logic signed [CoordW-1:0] cam_x;
		logic signed [CoordW-1:0] cam_y;
		logic signed [CoordW-1:0] cam_z;
		logic                     valid;
		logic [NumW:0]            den;  // 2*z
		lpcp_div_t                du;
		lpcp_div_t                dv;
	} lpcp_cell_t;

	function automatic logic signed [CoordW-1:0] sat20(input logic signed [39:0] v);
		if (v > 40'sd524287)
			return S20_MAX;
		else if (v < -40'sd524288)
			return S20_MIN;
		else
			return v[CoordW-1:0];
	endfunction

endpackage

// ===== hw/rtl/lpcp_if.sv =====
// ----------------------------------------------------------------------------
// lpcp_stream_if: valid/ready channel with a payload of a given width
// Source drives valid and data, sink drives ready.
// ----------------------------------------------------------------------------
interface lpcp_stream_if #(parameter int W = 60);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/lidar_point_camera_projection_core.sv =====
// ----------------------------------------------------------------------------
// lidar_point_camera_projection_core: lidar point to camera pixel projection
// Extrinsic rotate/translate, depth gate, pinhole projection to Q15.4 pixels.
// ----------------------------------------------------------------------------
// Accepts one point per cycle and returns one result per point, in order. The
// pipeline is a rotation product stage, a row-sum stage that also
// rounds, translates, saturates and applies the depth gate, a focal product
// stage, then a row of 37 identical division cells, each resolving one
// quotient bit of x*fx/z and y*fy/z, and a final sign/offset/saturate stage.
// The whole pipeline advances together and stalls only when the output
// register is full and not taken. Configuration writes take effect on points
// accepted afterwards; write only when idle.
module lidar_point_camera_projection_core
	import lpcp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	lpcp_stream_if.sink   pt,
	lpcp_stream_if.source res,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CfgIdxW-1:0]   cfg_index,
	input  logic [CfgDataW-1:0]  cfg_data
);

	// configuration registers
	logic [47:0]       rot0_q, rot1_q, rot2_q;
	logic [59:0]       trans_q;
	logic [31:0]       focal_q, pp_q;
	logic [DepthW-1:0] mind_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot0_q  <= ROT0_RST;
			rot1_q  <= ROT1_RST;
			rot2_q  <= ROT2_RST;
			trans_q <= TRANS_RST;
			focal_q <= FOCAL_RST;
			pp_q    <= PP_RST;
			mind_q  <= MIND_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ROT0:  rot0_q  <= cfg_data[47:0];
				REG_ROT1:  rot1_q  <= cfg_data[47:0];
				REG_ROT2:  rot2_q  <= cfg_data[47:0];
				REG_TRANS: trans_q <= cfg_data[59:0];
				REG_FOCAL: focal_q <= cfg_data[31:0];
				REG_PP:    pp_q    <= cfg_data[31:0];
				REG_MIND:  mind_q  <= cfg_data[DepthW-1:0];
				default: ;
			endcase
		end
	end

	// global advance: the pipeline moves when the output register can take data
	logic out_vld_q;
	logic adv;
	assign adv = !out_vld_q || res.ready;
	assign pt.ready = adv;

	// stage 1: nine coefficient products
	logic        v_s1;
	logic signed [35:0] prod_s1 [9];
	logic signed [CoordW-1:0] p_in [3];
	logic [47:0] rows [3];
	assign p_in[0] = pt.data[19:0];
	assign p_in[1] = pt.data[39:20];
	assign p_in[2] = pt.data[59:40];
	assign rows[0] = rot0_q;
	assign rows[1] = rot1_q;
	assign rows[2] = rot2_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 3; r++)
				for (int c = 0; c < 3; c++)
					prod_s1[r*3+c] <= $signed(rows[r][c*16 +: 16]) * p_in[c];
		end
	end

	// stage 2: row sums, round, translate, saturate; depth gate
	logic v_s2;
	logic signed [CoordW-1:0] cam_s2 [3];
	logic valid_s2;
	logic signed [CoordW-1:0] cam_c [3];

	always_comb begin
		logic signed [38:0] acc;
		logic signed [39:0] sum;
		for (int r = 0; r < 3; r++) begin
			acc = 39'(prod_s1[r*3]) + 39'(prod_s1[r*3+1]) + 39'(prod_s1[r*3+2])
				+ 39'sd8192;
			sum = 40'(acc >>> 14) + 40'($signed(trans_q[r*20 +: 20]));
			cam_c[r] = sat20(sum);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cam_s2 <= cam_c;
			valid_s2 <= cam_c[2] > $signed({11'd0, mind_q});
		end
	end

	// stage 3: focal products and division setup
	logic v_s3;
	lpcp_cell_t cell_in;
	logic signed [36:0] nu_c, nv_c;
	assign nu_c = cam_s2[0] * $signed({1'b0, focal_q[15:0]});
	assign nv_c = cam_s2[1] * $signed({1'b0, focal_q[31:16]});

	function automatic lpcp_div_t setup(input logic signed [36:0] n,
		input logic signed [CoordW-1:0] z, input logic [PixW-1:0] pp);
		lpcp_div_t     d;
		logic [NumW-1:0] mag;
		mag = n[36] ? NumW'(-n) : NumW'(n);
		d.neg = n[36];
		d.rem = '0;
		d.num = {mag, 1'b0} + (NumW+1)'(z[CoordW-2:0]);
		d.quo = '0;
		d.pp  = pp;
		return d;
	endfunction

	always_ff @(posedge clk) begin
		if (adv) begin
			cell_in.cam_x <= cam_s2[0];
			cell_in.cam_y <= cam_s2[1];
			cell_in.cam_z <= cam_s2[2];
			cell_in.valid <= valid_s2;
			cell_in.den   <= {(NumW+1-CoordW)'(0), cam_s2[2][CoordW-2:0], 1'b0};
			cell_in.du    <= setup(nu_c, cam_s2[2], pp_q[15:0]);
			cell_in.dv    <= setup(nv_c, cam_s2[2], pp_q[31:16]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= pt.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// row of division cells
	logic       cv [DivSteps+1];
	lpcp_cell_t cd [DivSteps+1];
	assign cv[0] = v_s3;
	assign cd[0] = cell_in;

	for (genvar g = 0; g < DivSteps; g++) begin : g_cell
		lpcp_div_cell u_cell (
			.clk(clk), .arst_n(arst_n), .adv(adv),
			.vld_in(cv[g]), .din(cd[g]),
			.vld_out(cv[g+1]), .dout(cd[g+1])
		);
	end

	// final: sign, offset, saturate, zero when invalid
	function automatic logic signed [CoordW-1:0] finish(input lpcp_div_t d);
		logic signed [39:0] q;
		q = d.neg ? -40'($signed({1'b0, d.quo})) : 40'($signed({1'b0, d.quo}));
		return sat20(q + 40'($signed({1'b0, d.pp})));
	endfunction

	lpcp_cell_t last;
	logic signed [CoordW-1:0] u_c, v_c;
	logic [5*CoordW:0] out_q;
	assign last = cd[DivSteps];
	assign u_c = last.valid ? finish(last.du) : '0;
	assign v_c = last.valid ? finish(last.dv) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= cv[DivSteps];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= {v_c, u_c, last.valid, last.cam_z, last.cam_y, last.cam_x};
		end
	end

	assign res.valid = out_vld_q;
	// layout: cam_x[19:0] cam_y[39:20] cam_z[59:40] valid[60] u[80:61] v[100:81]
	assign res.data = out_q;

`ifndef SYNTHESIS
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |=> res.valid && $stable(res.data))
		else $error("result changed while stalled");
	a_zero_pix: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.data[60] |-> res.data[100:61] == 40'd0)
		else $error("invalid point with nonzero pixel");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!res.valid |-> pt.ready)
		else $error("input stalled with empty output");
`endif

endmodule

// ===== hw/rtl/lpcp_div_cell.sv =====
// ----------------------------------------------------------------------------
// lpcp_div_cell: one restoring-division step for the u and v channels
// Registers the step result and hands it to the next cell.
// ----------------------------------------------------------------------------
module lpcp_div_cell
	import lpcp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       adv,
	input  logic       vld_in,
	input  lpcp_cell_t din,
	output logic       vld_out,
	output lpcp_cell_t dout
);

	logic       vld_q;
	lpcp_cell_t dat_q;
	lpcp_cell_t nxt;

	function automatic lpcp_div_t step(input lpcp_div_t d, input logic [NumW:0] den);
		lpcp_div_t     r;
		logic [NumW:0] t;
		r = d;
		t = {d.rem[NumW-1:0], d.num[NumW]};
		r.num = {d.num[NumW-1:0], 1'b0};
		if (t >= den) begin
			r.rem = t - den;
			r.quo = {d.quo[QuoW-2:0], 1'b1};
		end else begin
			r.rem = t;
			r.quo = {d.quo[QuoW-2:0], 1'b0};
		end
		return r;
	endfunction

	always_comb begin
		nxt = din;
		nxt.du = step(din.du, din.den);
		nxt.dv = step(din.dv, din.den);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dat_q <= nxt;
		end
	end

	assign vld_out = vld_q;
	assign dout = dat_q;

endmodule
